[src/srx_pkg.sv]
// Package: shared constants, types and the CRC-32 byte step for the packet receiver.
`default_nettype none
package srx_pkg;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [15:0] MIN_LENGTH   = 16'd9;
    localparam logic [15:0] LENGTH_RESET = 16'd25079;
    localparam logic [15:0] ID_NONE      = 16'hFFFF;

    // Header byte positions
    localparam logic [15:0] POS_SEQ_HI  = 16'd1;
    localparam logic [15:0] POS_SEQ_LO  = 16'd2;
    localparam logic [15:0] POS_SIZE_HI = 16'd3;
    localparam logic [15:0] POS_SIZE_LO = 16'd4;

    typedef enum logic [1:0] {
        ST_ACCEPTED = 2'd0,
        ST_IGNORED  = 2'd1,
        ST_CORRUPT  = 2'd2
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] ack_id;
        logic [7:0]  ack_checksum;
        logic [15:0] message_size;
        logic [31:0] data_offset;
    } result_t;

    // Reflected CRC-32, one byte, bitwise
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[src/srx_in_reg.sv]
// Input register for received bytes.
`default_nettype none
module srx_in_reg (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] data_byte,
    input  wire logic       advance,
    output logic            valid,
    output logic [7:0]      byte_q
);
    logic       valid_reg;
    logic [7:0] byte_reg;

    // Take a new byte when empty or when the held byte moves on
    assign in_ready = !valid_reg || advance;
    assign valid    = valid_reg;
    assign byte_q   = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            byte_reg <= data_byte;
        end
    end
endmodule
`default_nettype wire

[src/srx_proc.sv]
// Packet state: CRC accumulation, header capture and end-of-packet decision.
`default_nettype none
module srx_proc (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [15:0] cfg_data,
    input  wire logic        step,
    input  wire logic [7:0]  byte_in,
    output logic             is_last,
    output srx_pkg::result_t result
);
    import srx_pkg::*;

    logic [15:0] len_reg;
    logic [31:0] crc_reg,   crc_next;
    logic [15:0] pos_reg;
    logic [31:0] rcrc_reg,  rcrc_next;
    logic [15:0] seq_reg,   seq_next;
    logic [15:0] size_reg,  size_next;
    logic [15:0] last_id_reg, last_id_next;
    logic [31:0] total_reg, total_next;
    logic [15:0] len_eff;
    logic        crc_ok;
    logic        in_order;

    // Effective length, short lengths clamp to the minimum
    assign len_eff = (len_reg < MIN_LENGTH) ? MIN_LENGTH : len_reg;
    assign is_last = (pos_reg >= len_eff - 16'd1);

    // Per-byte updates and the decision on the last byte
    always_comb
    begin
        seq_next  = seq_reg;
        size_next = size_reg;
        if (pos_reg == POS_SEQ_HI)  seq_next  = {byte_in, seq_reg[7:0]};
        if (pos_reg == POS_SEQ_LO)  seq_next  = {seq_reg[15:8], byte_in};
        if (pos_reg == POS_SIZE_HI) size_next = {byte_in, size_reg[7:0]};
        if (pos_reg == POS_SIZE_LO) size_next = {size_reg[15:8], byte_in};

        crc_next  = crc_reg;
        rcrc_next = rcrc_reg;
        if (pos_reg < len_eff - 16'd4)
        begin
            if (byte_in != 8'd0)
            begin
                crc_next = crc32_byte(crc_reg, byte_in);
            end
        end
        else
        begin
            rcrc_next = {byte_in, rcrc_reg[31:8]};
        end

        crc_ok   = ((crc_next ^ CRC_INIT) == rcrc_next);
        // Signed compare against last + 1, no wrap
        in_order = ({seq_next[15], seq_next} == ({last_id_reg[15], last_id_reg} + 17'd1));

        last_id_next = last_id_reg;
        total_next   = total_reg;
        result.message_size = 16'd0;
        result.data_offset  = 32'd0;
        if (!crc_ok)
        begin
            result.status = ST_CORRUPT;
        end
        else
        begin
            result.message_size = size_next;
            if (in_order)
            begin
                result.status = ST_ACCEPTED;
                last_id_next  = seq_next;
                total_next    = total_reg + {16'd0, size_next};
            end
            else
            begin
                result.status = ST_IGNORED;
            end
            result.data_offset = total_next - {16'd0, size_next};
        end
        result.ack_id       = last_id_next;
        result.ack_checksum = 8'd1 + last_id_next[15:8] + last_id_next[7:0];
    end

    // Packet and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg     <= LENGTH_RESET;
            crc_reg     <= CRC_INIT;
            pos_reg     <= 16'd0;
            rcrc_reg    <= 32'd0;
            seq_reg     <= 16'd0;
            size_reg    <= 16'd0;
            last_id_reg <= ID_NONE;
            total_reg   <= 32'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                len_reg <= cfg_data;
            end
            if (step)
            begin
                if (is_last)
                begin
                    crc_reg     <= CRC_INIT;
                    pos_reg     <= 16'd0;
                    rcrc_reg    <= 32'd0;
                    seq_reg     <= 16'd0;
                    size_reg    <= 16'd0;
                    last_id_reg <= last_id_next;
                    total_reg   <= total_next;
                end
                else
                begin
                    crc_reg  <= crc_next;
                    pos_reg  <= pos_reg + 16'd1;
                    rcrc_reg <= rcrc_next;
                    seq_reg  <= seq_next;
                    size_reg <= size_next;
                end
            end
        end
    end
endmodule
`default_nettype wire

[src/srx_out_reg.sv]
// Result register holding one packet verdict until the consumer takes it.
`default_nettype none
module srx_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire srx_pkg::result_t result,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output srx_pkg::result_t      result_q
);
    import srx_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign out_valid = valid_reg;
    assign result_q  = result_reg;

    // Valid flag: set on load, cleared once the transaction completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end
endmodule
`default_nettype wire

[src/stop_and_wait_packet_receiver.sv]
// Stop-and-wait packet receiver: top level with CRC-32 check and ack generation.
//
// Usage:
//   Input channel (in_valid/in_ready, data_byte) carries the packet one byte per
//   transaction. A packet is packet_length bytes: header (sequence id in bytes 1-2,
//   message size in bytes 3-4, big-endian), payload, and a little-endian CRC-32.
//   Output channel (out_valid/out_ready) carries one transaction per packet, made on
//   its last byte: status, ack_id, ack_checksum, message_size, data_offset.
//   Config channel (cfg_valid/cfg_ready, cfg_data) writes packet_length; write it
//   only while no packet is in progress. cfg_ready is always high.
// Timing:
//   One byte per cycle unless a result waits for out_ready. A taken byte sits in
//   the input register and the packet logic acts on it in the next cycle; the
//   result loads as the last byte moves on. The single-byte CRC step sets the depth.
// Reset:
//   packet_length returns to 25079, byte count and CRC restart, no id accepted yet.
// Stall:
//   While a result waits for out_ready, bytes that do not end a packet keep
//   flowing; a packet's last byte waits in the input register, and in_ready drops.
`default_nettype none
module stop_and_wait_packet_receiver (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [15:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  data_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output srx_pkg::status_t status,
    output logic [15:0]      ack_id,
    output logic [7:0]       ack_checksum,
    output logic [15:0]      message_size,
    output logic [31:0]      data_offset
);
    import srx_pkg::*;

    logic    byte_valid;
    logic [7:0] byte_q;
    logic    advance;
    logic    is_last;
    result_t result;
    result_t result_q;

    assign cfg_ready = 1'b1;

    // Held byte moves on unless it ends a packet while the result slot is busy
    assign advance = byte_valid && (!is_last || !out_valid || out_ready);

    srx_in_reg u_in (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .advance   (advance),
        .valid     (byte_valid),
        .byte_q    (byte_q)
    );

    srx_proc u_proc (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .step     (advance),
        .byte_in  (byte_q),
        .is_last  (is_last),
        .result   (result)
    );

    srx_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && is_last),
        .result    (result),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .result_q  (result_q)
    );

    assign status       = result_q.status;
    assign ack_id       = result_q.ack_id;
    assign ack_checksum = result_q.ack_checksum;
    assign message_size = result_q.message_size;
    assign data_offset  = result_q.data_offset;

    // Checks
    a_checksum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ack_checksum == 8'(16'd1 + {8'd0, ack_id[15:8]} + {8'd0, ack_id[7:0]}))
        else $error("ack checksum does not match ack id");

    a_corrupt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == ST_CORRUPT) |-> (message_size == 16'd0 && data_offset == 32'd0))
        else $error("corrupt result carries size or offset");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !(advance && is_last))
        else $error("pending result overwritten");

    a_stall_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (byte_valid && is_last && out_valid && !out_ready))
        else $error("input stalled without a blocked result");
endmodule
`default_nettype wire

[bench/tb_top.sv]
// Testbench for the stop-and-wait packet receiver: stimulus, ack prediction and result checks.
module tb_top;
    import srx_pkg::*;

    localparam int RANDOM_BYTES  = 500;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 40_000;
    localparam int MAX_REPORTS   = 10;

    // Tracks receiver state and holds the acks it should produce, oldest first
    class ack_scoreboard;
        logic [15:0] length_reg;
        logic [31:0] crc_acc;
        logic [15:0] position;
        logic [31:0] trailer;
        logic [15:0] seq_id;
        logic [15:0] size_field;
        logic [15:0] last_id;
        logic [31:0] total_size;
        result_t     pending_acks[$];
        int          failures;
        int          bytes_taken;
        int          acks_seen;
        int          n_accepted;
        int          n_ignored;
        int          n_corrupt;

        function new();
            length_reg = LENGTH_RESET;
            last_id    = ID_NONE;
            total_size = '0;
            failures   = 0;
            bytes_taken = 0;
            acks_seen  = 0;
            n_accepted = 0;
            n_ignored  = 0;
            n_corrupt  = 0;
            clear_packet();
        endfunction

        // Reflected CRC-32, input bits taken LSB first
        static function logic [31:0] crc_shift_byte(input logic [31:0] crc, input logic [7:0] b);
            logic [31:0] c;
            c = crc;
            for (int k = 0; k < 8; k++)
            begin
                c = {1'b0, c[31:1]} ^ ((c[0] ^ b[k]) ? CRC_POLY : 32'd0);
            end
            return c;
        endfunction

        function void clear_packet();
            crc_acc    = CRC_INIT;
            position   = '0;
            trailer    = '0;
            seq_id     = '0;
            size_field = '0;
        endfunction

        function void set_length(input logic [15:0] v);
            length_reg = v;
        endfunction

        // One accepted byte; queues an ack when it closes the packet
        function void take_byte(input logic [7:0] b);
            logic [15:0] len;
            int          id_now;
            int          id_prev;
            result_t     ack;
            bytes_taken++;
            len = (length_reg < MIN_LENGTH) ? MIN_LENGTH : length_reg;
            if (position == POS_SEQ_HI)  seq_id[15:8] = b;
            if (position == POS_SEQ_LO)  seq_id[7:0] = b;
            if (position == POS_SIZE_HI) size_field[15:8] = b;
            if (position == POS_SIZE_LO) size_field[7:0] = b;

            // body bytes feed the CRC (zeros skipped), trailing bytes shift in
            if (position < len - 16'd4)
            begin
                if (b != 8'd0)
                    crc_acc = crc_shift_byte(crc_acc, b);
            end
            else
            begin
                trailer = {b, trailer[31:8]};
            end

            if (position < len - 16'd1)
            begin
                position = position + 16'd1;
                return;
            end

            // end of packet: classify
            if ((crc_acc ^ CRC_INIT) != trailer)
            begin
                ack.status       = ST_CORRUPT;
                ack.message_size = '0;
                ack.data_offset  = '0;
            end
            else
            begin
                ack.message_size = size_field;
                id_now  = $signed(seq_id);
                id_prev = $signed(last_id);
                if (id_now == id_prev + 1)
                begin
                    ack.status = ST_ACCEPTED;
                    last_id    = seq_id;
                    total_size = total_size + {16'd0, size_field};
                end
                else
                begin
                    ack.status = ST_IGNORED;
                end
                ack.data_offset = total_size - {16'd0, size_field};
            end
            ack.ack_id       = last_id;
            ack.ack_checksum = 8'd1 + last_id[15:8] + last_id[7:0];
            pending_acks.push_back(ack);
            clear_packet();
        endfunction

        function void check_ack(input result_t got);
            result_t want;
            acks_seen++;
            if (pending_acks.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected ack: status=%0d id=%h sum=%h size=%h offset=%h",
                             got.status, got.ack_id, got.ack_checksum, got.message_size,
                             got.data_offset);
                return;
            end
            want = pending_acks.pop_front();
            if (got.status != want.status || got.ack_id != want.ack_id ||
                got.ack_checksum != want.ack_checksum ||
                got.message_size != want.message_size ||
                got.data_offset != want.data_offset)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                begin
                    $display("ack mismatch: expected status=%0d id=%h sum=%h size=%h offset=%h",
                             want.status, want.ack_id, want.ack_checksum, want.message_size,
                             want.data_offset);
                    $display("              actual   status=%0d id=%h sum=%h size=%h offset=%h",
                             got.status, got.ack_id, got.ack_checksum, got.message_size,
                             got.data_offset);
                end
            end
            else
            begin
                case (got.status)
                    ST_ACCEPTED: n_accepted++;
                    ST_IGNORED:  n_ignored++;
                    default:     n_corrupt++;
                endcase
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [15:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    status_t     status;
    logic [15:0] ack_id;
    logic [7:0]  ack_checksum;
    logic [15:0] message_size;
    logic [31:0] data_offset;

    ack_scoreboard acks = new();
    logic [7:0]    pkt_bytes[$];
    int            send_idle_pct;
    int            recv_idle_pct;
    bit            hold_request;
    bit            hold_done;
    int            cycle_count;

    stop_and_wait_packet_receiver DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .ack_id       (ack_id),
        .ack_checksum (ack_checksum),
        .message_size (message_size),
        .data_offset  (data_offset)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Ack sink: checks each transaction and drives out_ready, with one long hold-off
    initial
    begin : ack_sink
        result_t got;
        int      hold_left;
        hold_left = 0;
        hold_done = 1'b0;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
            begin
                got.status       = status;
                got.ack_id       = ack_id;
                got.ack_checksum = ack_checksum;
                got.message_size = message_size;
                got.data_offset  = data_offset;
                acks.check_ack(got);
            end
            if (hold_request && !hold_done)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One byte transaction, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        acks.take_byte(b);
    endtask

    task automatic send_packet();
        foreach (pkt_bytes[i])
            send_byte(pkt_bytes[i]);
    endtask

    // Append the little-endian CRC-32 of the bytes so far, zeros skipped
    task automatic seal_packet();
        logic [31:0] crc;
        crc = CRC_INIT;
        foreach (pkt_bytes[i])
            if (pkt_bytes[i] != 8'd0)
                crc = ack_scoreboard::crc_shift_byte(crc, pkt_bytes[i]);
        crc = ~crc;
        pkt_bytes.push_back(crc[7:0]);
        pkt_bytes.push_back(crc[15:8]);
        pkt_bytes.push_back(crc[23:16]);
        pkt_bytes.push_back(crc[31:24]);
    endtask

    // Well-formed packet with random payload, zeros frequent
    task automatic fill_packet(input int len, input logic [15:0] id, input logic [15:0] size);
        pkt_bytes.delete();
        pkt_bytes.push_back(8'($urandom));
        pkt_bytes.push_back(id[15:8]);
        pkt_bytes.push_back(id[7:0]);
        pkt_bytes.push_back(size[15:8]);
        pkt_bytes.push_back(size[7:0]);
        while (pkt_bytes.size() < len - 4)
            pkt_bytes.push_back(($urandom_range(4) == 0) ? 8'h00 : 8'($urandom));
        seal_packet();
    endtask

    // Length write, only once all acks are in and the pipeline has drained
    task automatic write_length(input logic [15:0] v);
        in_valid <= 1'b0;
        @(posedge clk);
        while (acks.pending_acks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        acks.set_length(v);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [15:0] pick_size();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(2000));
        endcase
    endfunction

    // Main stimulus
    initial
    begin : stimulus
        int          random_count;
        int          len;
        int          kind;
        int          idx;
        logic [15:0] cfg_value;
        logic [15:0] next_id;

        rst_n        <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        data_byte    <= '0;
        hold_request = 1'b0;
        send_idle_pct = 33;
        recv_idle_pct = 50;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: length below minimum, extreme bytes, all three outcomes
        write_length(16'd0);
        pkt_bytes = '{8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF};
        seal_packet();
        send_packet();
        // all-zero packet repeats id 0, so it is ignored
        pkt_bytes = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
        seal_packet();
        send_packet();
        // length shrinks mid-packet: the next byte ends the packet
        write_length(16'd16);
        fill_packet(16, acks.last_id + 16'd1, 16'h0102);
        for (int i = 0; i < 10; i++)
            send_byte(pkt_bytes[i]);
        write_length(16'd9);
        send_byte(8'h5A);

        // Random phases, each with its own packet length
        random_count = 0;
        while (random_count < RANDOM_BYTES)
        begin
            if (random_count < RANDOM_BYTES / 3)
            begin
                send_idle_pct = 33;
                recv_idle_pct = 50;
            end
            else if (random_count < 2 * RANDOM_BYTES / 3)
            begin
                send_idle_pct = 50;
                recv_idle_pct = 33;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end

            case ($urandom_range(9))
                0:       cfg_value = 16'($urandom_range(8));
                1:       cfg_value = MIN_LENGTH;
                default: cfg_value = 16'($urandom_range(10, 24));
            endcase
            write_length(cfg_value);
            len = (cfg_value < MIN_LENGTH) ? MIN_LENGTH : cfg_value;

            // long receiver hold-off starts while packets are being sent
            if (send_idle_pct == 0)
                hold_request = 1'b1;

            repeat ($urandom_range(3, 6))
            begin
                next_id = acks.last_id + 16'd1;
                kind    = $urandom_range(99);
                if (kind < 60)
                begin
                    fill_packet(len, next_id, pick_size());
                end
                else if (kind < 75)
                begin
                    // stale or arbitrary id
                    if ($urandom_range(1) == 0)
                        fill_packet(len, next_id - 16'($urandom_range(1, 3)), pick_size());
                    else
                        fill_packet(len, 16'($urandom), pick_size());
                end
                else if (kind < 90)
                begin
                    // one bit flipped anywhere
                    fill_packet(len, next_id, pick_size());
                    idx = $urandom_range(len - 1);
                    pkt_bytes[idx] = pkt_bytes[idx] ^ (8'd1 << $urandom_range(7));
                end
                else
                begin
                    pkt_bytes.delete();
                    repeat (len) pkt_bytes.push_back(8'($urandom));
                end
                send_packet();
                random_count += len;
            end
        end

        // Drain
        in_valid <= 1'b0;
        while (acks.pending_acks.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Run covered %0d bytes and %0d acks: %0d accepted, %0d ignored, %0d corrupt.",
                 acks.bytes_taken, acks.acks_seen, acks.n_accepted, acks.n_ignored,
                 acks.n_corrupt);
        $display("Packet lengths ran from the clamped minimum to 24, with idle gaps and a long stall.");
        if (acks.failures == 0 && acks.pending_acks.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
